// ----- sv/five_point_derivative_stream_unit_defines.svh -----
// Assertion macros shared by the five-point derivative stream unit
`ifndef FIVE_POINT_DERIVATIVE_STREAM_UNIT_DEFINES_SVH
`define FIVE_POINT_DERIVATIVE_STREAM_UNIT_DEFINES_SVH
// same-cycle implication, checked outside reset
`define FPD_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked outside reset
`define FPD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- sv/fpd_pkg.sv -----
// Types, constants and the stencil function of the five-point derivative stream unit
package fpd_pkg;
	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned STEP_W = 32;
	localparam int unsigned SUM_W = SAMPLE_W + 8;
	localparam int unsigned MAG_W = SUM_W - 1;
	localparam int unsigned DEN_W = STEP_W + 4;
	localparam int unsigned CNT_W = $clog2(SAMPLE_W + 1);
	localparam int unsigned WIN_N = 5;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	typedef logic [2:0] pos_t;
	typedef logic [2:0] seen_t;

	localparam pos_t POS_FIRST = 3'd0;
	localparam pos_t POS_CENTRE = 3'd2;
	localparam pos_t POS_LAST = 3'd4;
	localparam seen_t SEEN_PRIMED = 3'd4;
	localparam seen_t SEEN_FULL = 3'd5;

	localparam logic signed [SAMPLE_W-1:0] ZERO_STEP_RESET = 32'sd66;
	localparam logic [SAMPLE_W-1:0] LIM_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] LIM_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

	localparam logic signed [6:0] COEF [WIN_N][WIN_N] = '{
		'{-7'sd25, 7'sd48, -7'sd36, 7'sd16, -7'sd3},
		'{-7'sd3, -7'sd10, 7'sd18, -7'sd6, 7'sd1},
		'{7'sd1, -7'sd8, 7'sd0, 7'sd8, -7'sd1},
		'{-7'sd1, 7'sd6, -7'sd18, 7'sd10, 7'sd3},
		'{7'sd3, -7'sd16, 7'sd36, -7'sd48, 7'sd25}
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic [STEP_W-1:0] step_size;
		logic final_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] derivative;
		logic zero_step_used;
		logic saturated;
		logic too_short;
		logic final_result;
	} out_word_t;

	typedef enum logic [1:0] {
		JOB_SHORT,
		JOB_ZERO,
		JOB_DIVIDE
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic signed [SUM_W-1:0] sum;
		logic [STEP_W-1:0] step;
		logic last;
	} job_t;

	typedef logic [WIN_N-1:0][SAMPLE_W-1:0] window_t;
	typedef logic [WIN_N-1:0][STEP_W-1:0] step_win_t;

	typedef enum logic {
		FR_IDLE,
		FR_EMIT
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREP,
		BK_DIV,
		BK_FIN,
		BK_OUT
	} back_state_t;

	function automatic logic signed [SUM_W-1:0] stencil_sum(pos_t pos, window_t win);
		logic signed [SUM_W-1:0] acc;
		acc = '0;
		if (pos <= POS_LAST) begin
			for (int i = 0; i < WIN_N; i++) begin
				acc = acc + SUM_W'(COEF[pos][i]) * SUM_W'($signed(win[i]));
			end
		end
		return acc;
	endfunction
endpackage

// ----- sv/fpd_front.sv -----
// Front end: sample window, sequence tracking and generation of derivative jobs
`include "five_point_derivative_stream_unit_defines.svh"
module fpd_front import fpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input in_word_t in_data,
	input logic in_valid,
	output logic in_ready,
	output job_t job,
	output logic job_valid,
	input logic job_ready
);
	front_state_t state_q, state_d;
	window_t win_q;
	step_win_t steps_q;
	seen_t seen_q;
	pos_t pos_q, last_q;
	logic fin_q, short_q;
	logic take, is_short, pos_end, job_take;

	assign take = in_valid && (state_q == FR_IDLE);
	assign is_short = in_data.final_sample && (seen_q < SEEN_PRIMED);
	assign pos_end = short_q || (pos_q == last_q);
	assign job_take = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			seen_q <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if (is_short) begin
					seen_q <= '0;
				end else if (seen_q != SEEN_FULL) begin
					seen_q <= seen_q + seen_t'(1);
				end
			end else if (job_take && pos_end && fin_q) begin
				seen_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		job_valid = 1'b0;
		job.kind = JOB_SHORT;
		job.sum = '0;
		job.step = '0;
		job.last = 1'b1;
		case (state_q)
			FR_IDLE: begin
				in_ready = 1'b1;
				if (take && (is_short || seen_q >= SEEN_PRIMED)) begin
					state_d = FR_EMIT;
				end
			end
			FR_EMIT: begin
				job_valid = 1'b1;
				if (!short_q) begin
					job.kind = (steps_q[pos_q] == '0) ? JOB_ZERO : JOB_DIVIDE;
					job.sum = stencil_sum(pos_q, win_q);
					job.step = steps_q[pos_q];
					job.last = fin_q && (pos_q == POS_LAST);
				end
				if (job_ready && pos_end) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fin_q <= in_data.final_sample;
			short_q <= is_short;
			pos_q <= (seen_q == SEEN_PRIMED) ? POS_FIRST : POS_CENTRE;
			last_q <= in_data.final_sample ? POS_LAST : POS_CENTRE;
			if (!is_short) begin
				win_q <= {in_data.sample_value, win_q[WIN_N-1:1]};
				steps_q <= {in_data.step_size, steps_q[WIN_N-1:1]};
			end
		end else if (job_take && !pos_end) begin
			pos_q <= pos_q + pos_t'(1);
		end
	end

	`FPD_ASSERT_NOW(a_seen_bound, 1'b1, seen_q <= SEEN_FULL, "sample count beyond five")
	`FPD_ASSERT_NEXT(a_last_clears, job_take && job.last, seen_q == '0, "sequence not cleared after last job")
endmodule

// ----- sv/fpd_fifo.sv -----
// Short job queue between the front end and the divider back end
`include "five_point_derivative_stream_unit_defines.svh"
module fpd_fifo import fpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input job_t push_data,
	input logic push_valid,
	output logic push_ready,
	output job_t pop_data,
	output logic pop_valid,
	input logic pop_ready
);
	job_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`FPD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= (PTR_W+1)'(QUEUE_DEPTH), "queue count overflow")
endmodule

// ----- sv/fpd_back.sv -----
// Back end: zero-step register, restoring divider, saturation and output register
`include "five_point_derivative_stream_unit_defines.svh"
module fpd_back import fpd_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic signed [SAMPLE_W-1:0] cfg_wdata,
	input job_t job,
	input logic job_valid,
	output logic job_ready,
	output out_word_t out_data,
	output logic out_valid,
	input logic out_ready
);
	localparam int unsigned NUM_W = MAG_W + FRAC_BITS;

	back_state_t state_q, state_d;
	logic signed [SAMPLE_W-1:0] zero_res_q;
	job_t job_q;
	logic neg_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [SAMPLE_W-1:0] quo_q, num_lo_q;
	logic [CNT_W-1:0] cnt_q;
	out_word_t res_q, out_q;
	logic out_valid_q;

	logic out_free;
	logic [MAG_W-1:0] mag;
	logic [DEN_W-1:0] den;
	logic [NUM_W-1:0] num;
	logic early_sat;
	logic [DEN_W:0] rem_sh;
	logic rem_ge;
	logic [SAMPLE_W-1:0] limit, quo_clamp;
	logic quo_sat;
	out_word_t prep_res, fin_res;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign den = DEN_W'({job_q.step, 3'b000}) + DEN_W'({job_q.step, 2'b00});
	assign mag = job_q.sum[SUM_W-1] ? MAG_W'(-job_q.sum) : MAG_W'(job_q.sum);
	assign num = NUM_W'(mag) << FRAC_BITS;
	assign early_sat = (num >> SAMPLE_W) >= NUM_W'(den);

	assign rem_sh = {rem_q, num_lo_q[SAMPLE_W-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};
	assign limit = neg_q ? LIM_NEG : LIM_POS;
	assign quo_sat = quo_q > limit;
	assign quo_clamp = quo_sat ? limit : quo_q;

	always_comb begin
		prep_res = '0;
		prep_res.final_result = job_q.last;
		if (job_q.kind == JOB_SHORT) begin
			prep_res.too_short = 1'b1;
		end else if (job_q.kind == JOB_ZERO) begin
			prep_res.derivative = zero_res_q;
			prep_res.zero_step_used = 1'b1;
		end else if (early_sat) begin
			prep_res.derivative = job_q.sum[SUM_W-1] ? LIM_NEG : LIM_POS;
			prep_res.saturated = 1'b1;
		end
		fin_res = res_q;
		fin_res.derivative = neg_q ? -quo_clamp : quo_clamp;
		fin_res.saturated = quo_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
			zero_res_q <= ZERO_STEP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				zero_res_q <= cfg_wdata;
			end
			if (state_q == BK_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = BK_PREP;
				end
			end
			BK_PREP: begin
				if (job_q.kind == JOB_DIVIDE && !early_sat) begin
					state_d = BK_DIV;
				end else begin
					state_d = BK_OUT;
				end
			end
			BK_DIV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: state_d = BK_OUT;
			BK_OUT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_q <= job;
				end
			end
			BK_PREP: begin
				neg_q <= job_q.sum[SUM_W-1];
				den_q <= den;
				rem_q <= DEN_W'(num >> SAMPLE_W);
				num_lo_q <= num[SAMPLE_W-1:0];
				quo_q <= '0;
				cnt_q <= CNT_W'(SAMPLE_W);
				res_q <= prep_res;
			end
			BK_DIV: begin
				rem_q <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
				quo_q <= {quo_q[SAMPLE_W-2:0], rem_ge};
				num_lo_q <= num_lo_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			BK_FIN: begin
				res_q <= fin_res;
			end
			BK_OUT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	`FPD_ASSERT_NOW(a_rem_below_den, state_q == BK_DIV, rem_q < den_q, "remainder over divisor")
endmodule

// ----- sv/five_point_derivative_stream_unit.sv -----
// Top level of the five-point derivative stream unit: front end, job queue and divider
//
//  channel | signals                     | handshake
//  --------+-----------------------------+----------------------------
//  in      | in_data, in_valid, in_ready | word taken on valid & ready
//  out     | out_data, out_valid, out_ready | word taken on valid & ready
//  cfg     | cfg_we, cfg_wdata           | write on cfg_we, no wait
//
// Back end order per result: load, setup, restoring divider with one quotient
// bit per cycle, clamp, output register. Zero-step, short and clamped-early
// results skip the divider and clamp. The front end takes one word per cycle
// until a sequence needs results, then holds input while it queues up to five
// jobs, one per cycle while the queue has room, into a four-entry queue.
// Reset clears control state and sets the zero-step result to 66; no clearing pass.
module five_point_derivative_stream_unit import fpd_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic signed [SAMPLE_W-1:0] cfg_wdata,
	input in_word_t in_data,
	input logic in_valid,
	output logic in_ready,
	output out_word_t out_data,
	output logic out_valid,
	input logic out_ready
);
	job_t fr_job, bk_job;
	logic fr_job_valid, fr_job_ready, bk_job_valid, bk_job_ready;

	fpd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.job(fr_job),
		.job_valid(fr_job_valid),
		.job_ready(fr_job_ready)
	);

	fpd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(fr_job),
		.push_valid(fr_job_valid),
		.push_ready(fr_job_ready),
		.pop_data(bk_job),
		.pop_valid(bk_job_valid),
		.pop_ready(bk_job_ready)
	);

	fpd_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.job(bk_job),
		.job_valid(bk_job_valid),
		.job_ready(bk_job_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);
endmodule
